/* rtl/kway_sorted_merge_top_macros.svh */
// ----------------------------------------------------------------------------
// kway sorted merge assertion macros
// shared property forms for the merge block checks
// ----------------------------------------------------------------------------
`ifndef KWAY_SORTED_MERGE_TOP_MACROS_SVH
`define KWAY_SORTED_MERGE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define KWSM_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KWSM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/kwsm_pkg.sv */
// ----------------------------------------------------------------------------
// kwsm_pkg
// types, sizes and codes shared by the k-way sorted merge block
// ----------------------------------------------------------------------------
package kwsm_pkg;

   localparam int LIST_COUNT = 4;
   localparam int LIST_DEPTH = 16;

   localparam int LIST_IDX_W = $clog2(LIST_COUNT);
   localparam int TREE_N     = 1 << LIST_IDX_W;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int FILL_W     = $clog2(LIST_DEPTH + 1);
   localparam int CFG_W      = 3;
   localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

   typedef logic signed [31:0] elem_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_DROPPED = 2'd1,
      ST_GIVEN   = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] list_select;
      elem_type   element_value;
   } req_type;

   typedef struct packed {
      elem_type   merged_value;
      status_type status;
      logic       is_last;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctrl_type;

   typedef struct packed {
      logic not_empty;
      logic single;
      logic full;
   } fifo_stat_type;

endpackage

/* rtl/kwsm_list_fifo.sv */
// ----------------------------------------------------------------------------
// kwsm_list_fifo
// one bounded list with a registered head value and a prefetched next value
// ----------------------------------------------------------------------------
module kwsm_list_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  kwsm_pkg::fifo_ctrl_type ctrl,
   input  kwsm_pkg::elem_type      push_data,
   output kwsm_pkg::fifo_stat_type stat,
   output kwsm_pkg::elem_type      head_value
);

   kwsm_pkg::elem_type mem_ff [kwsm_pkg::LIST_DEPTH];

   logic [kwsm_pkg::ADDR_W-1:0] head_ptr_ff;
   logic [kwsm_pkg::ADDR_W-1:0] head_ptr_in;
   logic [kwsm_pkg::FILL_W-1:0] fill_ff;
   logic [kwsm_pkg::FILL_W-1:0] fill_in;
   logic [kwsm_pkg::FILL_W:0]   tail_sum;
   logic [kwsm_pkg::ADDR_W-1:0] tail_addr;
   logic [kwsm_pkg::ADDR_W-1:0] head_next;
   logic [kwsm_pkg::ADDR_W-1:0] rd_addr;

   kwsm_pkg::elem_type head_value_ff;
   kwsm_pkg::elem_type rd_data_ff;
   kwsm_pkg::elem_type byp_data_ff;
   logic               byp_hit_ff;
   kwsm_pkg::elem_type second_value;

   // tail slot wraps around the list
   always_comb begin
      tail_sum = (kwsm_pkg::FILL_W + 1)'(head_ptr_ff) + (kwsm_pkg::FILL_W + 1)'(fill_ff);
      if (tail_sum >= (kwsm_pkg::FILL_W + 1)'(kwsm_pkg::LIST_DEPTH)) begin
         tail_addr = kwsm_pkg::ADDR_W'(tail_sum - (kwsm_pkg::FILL_W + 1)'(kwsm_pkg::LIST_DEPTH));
      end else begin
         tail_addr = kwsm_pkg::ADDR_W'(tail_sum);
      end
   end

   always_comb begin
      if (head_ptr_ff == kwsm_pkg::ADDR_W'(kwsm_pkg::LIST_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = head_ptr_ff + 1'b1;
      end
   end

   always_comb begin
      head_ptr_in = head_ptr_ff;
      fill_in     = fill_ff;
      if (ctrl.clear) begin
         head_ptr_in = '0;
         fill_in     = '0;
      end else if (ctrl.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctrl.pop) begin
         head_ptr_in = head_next;
         fill_in     = fill_ff - 1'b1;
      end
   end

   // slot after the head as it stands after this edge
   always_comb begin
      if (head_ptr_in == kwsm_pkg::ADDR_W'(kwsm_pkg::LIST_DEPTH - 1)) begin
         rd_addr = '0;
      end else begin
         rd_addr = head_ptr_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         fill_ff     <= '0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[tail_addr] <= push_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      byp_hit_ff  <= ctrl.push && (tail_addr == rd_addr);
      byp_data_ff <= push_data;
   end

   assign second_value = byp_hit_ff ? byp_data_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.push && (fill_ff == '0)) begin
         head_value_ff <= push_data;
      end else if (ctrl.pop) begin
         head_value_ff <= second_value;
      end
   end

   assign head_value     = head_value_ff;
   assign stat.not_empty = (fill_ff != '0);
   assign stat.single    = (fill_ff == kwsm_pkg::FILL_W'(1));
   assign stat.full      = (fill_ff == kwsm_pkg::FILL_W'(kwsm_pkg::LIST_DEPTH));

endmodule

/* rtl/kwsm_min_select.sv */
// ----------------------------------------------------------------------------
// kwsm_min_select
// compare tree picking the smallest valid head, lowest list on a tie
// ----------------------------------------------------------------------------
module kwsm_min_select (
   input  logic [kwsm_pkg::LIST_COUNT-1:0]  head_valid,
   input  kwsm_pkg::elem_type               head_value [kwsm_pkg::LIST_COUNT],
   output logic                             found,
   output logic [kwsm_pkg::LIST_IDX_W-1:0]  best_idx,
   output kwsm_pkg::elem_type               best_value
);

   logic                            node_valid [kwsm_pkg::LIST_IDX_W+1][kwsm_pkg::TREE_N];
   kwsm_pkg::elem_type              node_value [kwsm_pkg::LIST_IDX_W+1][kwsm_pkg::TREE_N];
   logic [kwsm_pkg::LIST_IDX_W-1:0] node_idx   [kwsm_pkg::LIST_IDX_W+1][kwsm_pkg::TREE_N];

   always_comb begin
      logic take_right;
      for (int l = 0; l <= kwsm_pkg::LIST_IDX_W; l++) begin
         for (int n = 0; n < kwsm_pkg::TREE_N; n++) begin
            node_valid[l][n] = 1'b0;
            node_value[l][n] = '0;
            node_idx[l][n]   = '0;
         end
      end
      for (int n = 0; n < kwsm_pkg::TREE_N; n++) begin
         if (n < kwsm_pkg::LIST_COUNT) begin
            node_valid[0][n] = head_valid[n];
            node_value[0][n] = head_value[n];
         end
         node_idx[0][n] = kwsm_pkg::LIST_IDX_W'(n);
      end
      for (int l = 0; l < kwsm_pkg::LIST_IDX_W; l++) begin
         for (int n = 0; n < (kwsm_pkg::TREE_N >> (l + 1)); n++) begin
            take_right = node_valid[l][2*n+1] &&
                         (!node_valid[l][2*n] || (node_value[l][2*n+1] < node_value[l][2*n]));
            if (take_right) begin
               node_valid[l+1][n] = 1'b1;
               node_value[l+1][n] = node_value[l][2*n+1];
               node_idx[l+1][n]   = node_idx[l][2*n+1];
            end else begin
               node_valid[l+1][n] = node_valid[l][2*n];
               node_value[l+1][n] = node_value[l][2*n];
               node_idx[l+1][n]   = node_idx[l][2*n];
            end
         end
      end
   end

   assign found      = node_valid[kwsm_pkg::LIST_IDX_W][0];
   assign best_idx   = node_idx[kwsm_pkg::LIST_IDX_W][0];
   assign best_value = node_value[kwsm_pkg::LIST_IDX_W][0];

endmodule

/* rtl/kway_sorted_merge_top.sv */
// ----------------------------------------------------------------------------
// kway_sorted_merge_top
// k-way merge of ascending lists held as bounded fifos
// ----------------------------------------------------------------------------
// channel   ports                         transfer
// request   start, busy, req_data         start high and busy low at the edge
// response  rsp_valid, rsp_data           one cycle strobe, always taken
// csr       csr_wr_en, csr_wr_data        written when csr_wr_en is high
//
// one transaction per cycle; after the accepting edge the response passes through
// the request register, then list update and compare tree into the response register
// busy stays low; lists are updated at the edge that loads the response register, so back to back
// transactions see each other
// synchronous reset empties all lists and sets lists in use to four
// the receiver cannot stall, so responses never wait
// ----------------------------------------------------------------------------
`include "kway_sorted_merge_top_macros.svh"

module kway_sorted_merge_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  kwsm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output kwsm_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [kwsm_pkg::CFG_W-1:0]    csr_wr_data
);

   logic                        req_valid_ff;
   kwsm_pkg::req_type           req_data_ff;
   logic                        rsp_valid_ff;
   kwsm_pkg::rsp_type           rsp_data_ff;
   kwsm_pkg::rsp_type           rsp_data_in;
   logic [kwsm_pkg::CFG_W-1:0]  lists_in_use_ff;

   kwsm_pkg::fifo_ctrl_type     fifo_ctrl  [kwsm_pkg::LIST_COUNT];
   kwsm_pkg::fifo_stat_type     fifo_stat  [kwsm_pkg::LIST_COUNT];
   kwsm_pkg::elem_type          head_value [kwsm_pkg::LIST_COUNT];

   logic [kwsm_pkg::LIST_COUNT-1:0] active_mask;
   logic [kwsm_pkg::LIST_COUNT-1:0] live_mask;
   logic [kwsm_pkg::LIST_COUNT-1:0] single_mask;
   logic [kwsm_pkg::LIST_COUNT-1:0] full_mask;
   logic [kwsm_pkg::LIST_COUNT-1:0] push_mask;
   logic [kwsm_pkg::LIST_COUNT-1:0] pop_mask;

   logic                            is_load;
   logic                            is_pull;
   logic                            is_clear;
   logic                            found;
   logic [kwsm_pkg::LIST_IDX_W-1:0] best_idx;
   kwsm_pkg::elem_type              best_value;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lists_in_use_ff <= kwsm_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         lists_in_use_ff <= csr_wr_data;
      end
   end

   always_comb begin
      is_load  = 1'b0;
      is_pull  = 1'b0;
      is_clear = 1'b0;
      case (kwsm_pkg::opcode_type'(req_data_ff.opcode))
         kwsm_pkg::OP_LOAD: begin
            is_load = req_valid_ff;
         end
         kwsm_pkg::OP_PULL: begin
            is_pull = req_valid_ff;
         end
         kwsm_pkg::OP_CLEAR: begin
            is_clear = req_valid_ff;
         end
         default: begin
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < kwsm_pkg::LIST_COUNT; gi++) begin : g_list
         assign active_mask[gi] = (32'(lists_in_use_ff) > gi);
         assign live_mask[gi]   = active_mask[gi] && fifo_stat[gi].not_empty;
         assign single_mask[gi] = fifo_stat[gi].single;
         assign full_mask[gi]   = fifo_stat[gi].full;
         assign push_mask[gi]   = is_load && (32'(req_data_ff.list_select) == gi) &&
                                  !fifo_stat[gi].full;
         assign pop_mask[gi]    = is_pull && found &&
                                  (32'(best_idx) == gi);

         assign fifo_ctrl[gi].push  = push_mask[gi];
         assign fifo_ctrl[gi].pop   = pop_mask[gi];
         assign fifo_ctrl[gi].clear = is_clear;

         kwsm_list_fifo u_list (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (fifo_ctrl[gi]),
            .push_data  (req_data_ff.element_value),
            .stat       (fifo_stat[gi]),
            .head_value (head_value[gi])
         );
      end
   endgenerate

   kwsm_min_select u_min_select (
      .head_valid (live_mask),
      .head_value (head_value),
      .found      (found),
      .best_idx   (best_idx),
      .best_value (best_value)
   );

   always_comb begin
      rsp_data_in.merged_value = '0;
      rsp_data_in.status       = kwsm_pkg::ST_DONE;
      rsp_data_in.is_last      = 1'b0;
      if (is_load) begin
         if (push_mask == '0) begin
            rsp_data_in.status = kwsm_pkg::ST_DROPPED;
         end
      end else if (is_pull) begin
         if (found) begin
            rsp_data_in.merged_value = best_value;
            rsp_data_in.status       = kwsm_pkg::ST_GIVEN;
            rsp_data_in.is_last      = ((pop_mask & single_mask) != '0) &&
                                       ((live_mask & (live_mask - 1'b1)) == '0);
         end else begin
            rsp_data_in.status = kwsm_pkg::ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KWSM_ASSERT_NEXT(a_rsp_follows_req, req_valid_ff, rsp_valid, "transaction lost its response")
   `KWSM_ASSERT_NOW(a_last_only_given, rsp_valid && rsp_data.is_last, rsp_data.status == kwsm_pkg::ST_GIVEN, "last flag on a non-given response")
   `KWSM_ASSERT_NOW(a_single_pop, 1'b1, $onehot0(pop_mask), "more than one list popped")
   `KWSM_ASSERT_NOW(a_no_push_full, 1'b1, (push_mask & full_mask) == '0, "push into a full list")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// k-way sorted merge: a table of directed transactions, then random phases of
// load, pull, clear and noise bursts under each lists-in-use setting, every response
// checked in order against the table or a local model of the lists
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         QUIET_LIMIT = 2000;
   localparam int         PHASE_ITEMS = 80;
   localparam int         PHASE_COUNT = 8;

   typedef struct {
      kwsm_pkg::req_type req;
      int                reps;
      bit                typed;
      kwsm_pkg::rsp_type rsp;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   kwsm_pkg::req_type           req_data;
   logic                        rsp_valid;
   kwsm_pkg::rsp_type           rsp_data;
   logic                        csr_wr_en;
   logic [kwsm_pkg::CFG_W-1:0]  csr_wr_data;

   kwsm_pkg::elem_type          list_mem [kwsm_pkg::LIST_COUNT][kwsm_pkg::LIST_DEPTH];
   int unsigned                 list_head [kwsm_pkg::LIST_COUNT];
   int unsigned                 list_fill [kwsm_pkg::LIST_COUNT];
   int unsigned                 merge_width;
   kwsm_pkg::elem_type          list_tail [kwsm_pkg::LIST_COUNT];
   kwsm_pkg::rsp_type           merge_out_q [$];
   stim_row_type                stim_rows [$];
   logic [kwsm_pkg::CFG_W-1:0]  width_plan [PHASE_COUNT] = '{3'd2, 3'd0, 3'd7, 3'd1, 3'd3,
                                                             3'd5, 3'd4, 3'd6};
   int                          fail_count = 0;
   int                          quiet_cycles = 0;
   bit                          idle_on = 1'b1;

   kway_sorted_merge_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic kwsm_pkg::rsp_type next_merge_out(kwsm_pkg::req_type r);
      kwsm_pkg::rsp_type  out;
      int unsigned        sel;
      int unsigned        n;
      int unsigned        best;
      int unsigned        remaining;
      bit                 found;
      kwsm_pkg::elem_type best_val;
      out = '0;
      out.status = kwsm_pkg::ST_DONE;
      case (r.opcode)
         kwsm_pkg::OP_LOAD: begin
            sel = 32'(r.list_select);
            if (sel >= kwsm_pkg::LIST_COUNT || list_fill[sel] >= kwsm_pkg::LIST_DEPTH) begin
               out.status = kwsm_pkg::ST_DROPPED;
            end else begin
               list_mem[sel][(list_head[sel] + list_fill[sel]) % kwsm_pkg::LIST_DEPTH] =
                  r.element_value;
               list_fill[sel]++;
            end
         end
         kwsm_pkg::OP_PULL: begin
            n = (merge_width > kwsm_pkg::LIST_COUNT) ? kwsm_pkg::LIST_COUNT : merge_width;
            found = 1'b0;
            best = 0;
            best_val = '0;
            for (int i = 0; i < n; i++) begin
               if (list_fill[i] != 0 && (!found || list_mem[i][list_head[i]] < best_val)) begin
                  found = 1'b1;
                  best = i;
                  best_val = list_mem[i][list_head[i]];
               end
            end
            if (!found) begin
               out.status = kwsm_pkg::ST_EMPTY;
            end else begin
               list_head[best] = (list_head[best] + 1) % kwsm_pkg::LIST_DEPTH;
               list_fill[best]--;
               remaining = 0;
               for (int i = 0; i < n; i++) remaining += list_fill[i];
               out.merged_value = best_val;
               out.status = kwsm_pkg::ST_GIVEN;
               out.is_last = (remaining == 0);
            end
         end
         kwsm_pkg::OP_CLEAR: begin
            for (int i = 0; i < kwsm_pkg::LIST_COUNT; i++) begin
               list_head[i] = 0;
               list_fill[i] = 0;
            end
         end
         default: ;
      endcase
      return out;
   endfunction

   task automatic send_req(input kwsm_pkg::req_type r, input bit typed,
                           input kwsm_pkg::rsp_type fixed);
      kwsm_pkg::rsp_type predicted;
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = next_merge_out(r);
      merge_out_q.push_back(typed ? fixed : predicted);
      if (idle_on && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain_results;
      start <= 1'b0;
      @(posedge clock);
      while (merge_out_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_lists_in_use(input logic [kwsm_pkg::CFG_W-1:0] v);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      merge_width = 32'(v);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [1:0] sel, input logic [31:0] val,
                          input int reps, input bit typed, input kwsm_pkg::status_type st,
                          input logic [31:0] mv, input logic last);
      stim_row_type row;
      row.req.opcode = op;
      row.req.list_select = sel;
      row.req.element_value = val;
      row.reps = reps;
      row.typed = typed;
      row.rsp.merged_value = mv;
      row.rsp.status = st;
      row.rsp.is_last = last;
      stim_rows.push_back(row);
   endtask

   always @(posedge clock) begin : rsp_check
      kwsm_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (merge_out_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected transaction: value %0d status %0d last %0d",
                     $time, rsp_data.merged_value, rsp_data.status, rsp_data.is_last);
         end else begin
            want = merge_out_q.pop_front();
            if (rsp_data.merged_value !== want.merged_value) begin
               fail_count++;
               $display("%0t: merged_value expected %0d got %0d",
                        $time, want.merged_value, rsp_data.merged_value);
            end
            if (rsp_data.status !== want.status) begin
               fail_count++;
               $display("%0t: status expected %0d got %0d",
                        $time, want.status, rsp_data.status);
            end
            if (rsp_data.is_last !== want.is_last) begin
               fail_count++;
               $display("%0t: is_last expected %0d got %0d",
                        $time, want.is_last, rsp_data.is_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** kway_sorted_merge_top: FAILED **");
         $finish;
      end
   end

   initial begin
      kwsm_pkg::req_type r;
      int                left;
      int                burst;
      int                kind;
      int                sel;
      longint            nv;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      for (int i = 0; i < kwsm_pkg::LIST_COUNT; i++) begin
         list_head[i] = 0;
         list_fill[i] = 0;
         list_tail[i] = '0;
         for (int j = 0; j < kwsm_pkg::LIST_DEPTH; j++) list_mem[i][j] = '0;
      end
      merge_width = 32'(kwsm_pkg::CFG_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed transactions
      add_row(kwsm_pkg::OP_PULL,  2'd0, 32'h0,        1,  1, kwsm_pkg::ST_EMPTY,   32'h0, 1'b0);
      add_row(kwsm_pkg::OP_LOAD,  2'd0, 32'h80000000, 1,  1, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(kwsm_pkg::OP_LOAD,  2'd1, 32'h7fffffff, 1,  1, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(OP_UNUSED,          2'd3, 32'hffffffff, 1,  1, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(kwsm_pkg::OP_LOAD,  2'd2, 32'h0,        16, 0, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(kwsm_pkg::OP_LOAD,  2'd2, 32'h1,        1,  1, kwsm_pkg::ST_DROPPED, 32'h0, 1'b0);
      add_row(kwsm_pkg::OP_LOAD,  2'd3, 32'h0,        1,  0, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(kwsm_pkg::OP_PULL,  2'd0, 32'h0,        1,  1, kwsm_pkg::ST_GIVEN,
              32'h80000000, 1'b0);
      add_row(kwsm_pkg::OP_PULL,  2'd3, 32'hffffffff, 2,  0, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(kwsm_pkg::OP_CLEAR, 2'd0, 32'h0,        1,  1, kwsm_pkg::ST_DONE,    32'h0, 1'b0);
      add_row(kwsm_pkg::OP_PULL,  2'd0, 32'h0,        1,  1, kwsm_pkg::ST_EMPTY,   32'h0, 1'b0);
      foreach (stim_rows[i]) begin
         for (int k = 0; k < stim_rows[i].reps; k++) begin
            send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
         end
      end

      // random phases: ascending load bursts, pull bursts, clears and noise
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_lists_in_use(width_plan[phase]);
         idle_on = (phase != 2);
         left = PHASE_ITEMS;
         while (left > 0) begin
            kind = $urandom_range(0, 99);
            burst = (kind < 45) ? $urandom_range(1, 20) :
                    (kind < 90) ? $urandom_range(1, 24) :
                    (kind < 95) ? 1 : $urandom_range(1, 6);
            for (int k = 0; k < burst && left > 0; k++) begin
               sel = $urandom_range(0, kwsm_pkg::LIST_COUNT - 1);
               r.list_select = 2'(sel);
               r.element_value = $urandom;
               if (kind < 45) begin
                  r.opcode = kwsm_pkg::OP_LOAD;
                  if (list_fill[sel] == 0) begin
                     list_tail[sel] = $urandom;
                  end else begin
                     nv = longint'(list_tail[sel]) +
                          (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 20));
                     if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                     list_tail[sel] = nv[31:0];
                  end
                  r.element_value = list_tail[sel];
               end else if (kind < 90) begin
                  r.opcode = kwsm_pkg::OP_PULL;
               end else if (kind < 95) begin
                  r.opcode = kwsm_pkg::OP_CLEAR;
               end else begin
                  r.opcode = 2'($urandom_range(0, 3));
               end
               send_req(r, 1'b0, '0);
               if (r.opcode != OP_UNUSED) left--;
               if (phase == 5 && left == PHASE_ITEMS / 2) drain_results();
            end
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && merge_out_q.size() == 0) begin
         $display("** kway_sorted_merge_top: PASSED **");
      end else begin
         $display("** kway_sorted_merge_top: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/kwsm_pkg.sv
rtl/kwsm_list_fifo.sv
rtl/kwsm_min_select.sv
rtl/kway_sorted_merge_top.sv
sim/tb_top.sv
